// ===== hw/rtl/sgd_pkg.sv =====
package sgd_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int COLUMNS_BITS   = 11;
   localparam int ROWS_BITS      = 16;
   localparam int SCALE_BITS     = 16;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [1:0]                dv_sel_type;

   localparam csr_index_type CSR_COLUMNS = 2'd0;
   localparam csr_index_type CSR_ROWS    = 2'd1;
   localparam csr_index_type CSR_SCALE   = 2'd2;

   localparam logic [COLUMNS_BITS-1:0] COLUMNS_RESET = 11'd1024;
   localparam logic [ROWS_BITS-1:0]    ROWS_RESET    = 16'd1;
   localparam logic [SCALE_BITS-1:0]   SCALE_RESET   = 16'd1;

   // y difference selection
   localparam dv_sel_type DV_TOP_BOTTOM = 2'd0;
   localparam dv_sel_type DV_V_BOTTOM   = 2'd1;
   localparam dv_sel_type DV_TOP_BELOW  = 2'd2;
   localparam dv_sel_type DV_V_BELOW    = 2'd3;

   localparam int RESULT_QUEUE_DEPTH = 8;

endpackage

// ===== hw/rtl/sgd_req_if.sv =====
interface sgd_req_if #(
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] u_value;
   logic signed [VALUE_BITS-1:0] v_value;
   logic signed [VALUE_BITS-1:0] top_value;
   logic signed [VALUE_BITS-1:0] bottom_value;

   modport source (output valid, u_value, v_value, top_value, bottom_value, input ready);
   modport sink (input valid, u_value, v_value, top_value, bottom_value, output ready);
endinterface

// ===== hw/rtl/sgd_rsp_if.sv =====
interface sgd_rsp_if #(
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] divergence;
   logic                         last_of_run;

   modport source (output valid, divergence, last_of_run, input ready);
   modport sink (input valid, divergence, last_of_run, output ready);
endinterface

// ===== hw/rtl/staggered_grid_divergence_unit.sv =====
// Staggered-grid divergence, periodic in x, over a raster stream of grid cells.
// req_chan carries one cell per item (u, v and the column's top and bottom
// boundary values); rsp_chan carries scaled, saturated divergence results.
// csr_* writes columns, rows and scale; write them only while the block idles.
// A cell's result appears once the next cell of its row has been taken; the
// last cell of a row yields two results, the second flagged last_of_run.
// From the item that completes a result to rsp valid, the result passes the
// accept stage register, the result queue, the scale multiply register and
// the output register; a receiver stall can hold it on the way.
// Throughput: one item per clock while the result queue has room; a row of N
// cells yields N results, so the single multiplier keeps pace. The registered
// v line memory read is forwarded when back-to-back items hit the same column.
// Reset clears the row and column counters, the held values and the result
// queue; the v line memory is not cleared and is written by the first row.
// When the receiver stalls, results collect in an 8-entry queue; req ready
// drops while the queue cannot take two results for each item in flight.
module staggered_grid_divergence_unit #(
   parameter int MAX_COLUMNS = 1024,
   parameter int VALUE_BITS  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  sgd_pkg::csr_index_type             csr_index,
   input  logic [sgd_pkg::CSR_DATA_BITS-1:0]  csr_data,
   sgd_req_if.sink                            req_chan,
   sgd_rsp_if.source                          rsp_chan
);

   localparam int VB        = VALUE_BITS;
   localparam int DV_BITS   = VB + 1;
   localparam int SUM_BITS  = VB + 2;
   localparam int PROD_BITS = VB + sgd_pkg::SCALE_BITS + 1;
   localparam int IDX_BITS  = $clog2(MAX_COLUMNS);
   localparam int COL_BITS  = (IDX_BITS + 1 > sgd_pkg::COLUMNS_BITS) ?
                              IDX_BITS + 1 : sgd_pkg::COLUMNS_BITS;
   localparam int QDEPTH    = sgd_pkg::RESULT_QUEUE_DEPTH;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);
   localparam int QCHK_BITS = QCNT_BITS + 2;

   typedef struct packed {
      logic [IDX_BITS-1:0]   idx;
      logic                  first;
      logic                  last_col;
      sgd_pkg::dv_sel_type   dv_sel;
      logic                  fwd;
      logic [VB-1:0]         fwd_v;
      logic [VB-1:0]         u;
      logic [VB-1:0]         v;
      logic [VB-1:0]         top;
      logic [VB-1:0]         bot;
   } cell_type;

   typedef struct packed {
      logic          last;
      logic [VB-1:0] div;
   } result_type;

   function automatic logic [VB-1:0] sat_sum(input logic signed [SUM_BITS-1:0] a);
      priority if (!a[SUM_BITS-1] && (|a[SUM_BITS-2:VB-1])) begin
         return {1'b0, {(VB-1){1'b1}}};
      end else if (a[SUM_BITS-1] && !(&a[SUM_BITS-2:VB-1])) begin
         return {1'b1, {(VB-1){1'b0}}};
      end else begin
         return a[VB-1:0];
      end
   endfunction

   function automatic logic [VB-1:0] sat_prod(input logic signed [PROD_BITS-1:0] a);
      priority if (!a[PROD_BITS-1] && (|a[PROD_BITS-2:VB-1])) begin
         return {1'b0, {(VB-1){1'b1}}};
      end else if (a[PROD_BITS-1] && !(&a[PROD_BITS-2:VB-1])) begin
         return {1'b1, {(VB-1){1'b0}}};
      end else begin
         return a[VB-1:0];
      end
   endfunction

   // configuration
   logic [sgd_pkg::COLUMNS_BITS-1:0] columns_ff;
   logic [sgd_pkg::ROWS_BITS-1:0]    rows_ff;
   logic [sgd_pkg::SCALE_BITS-1:0]   scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= sgd_pkg::COLUMNS_RESET;
         rows_ff    <= sgd_pkg::ROWS_RESET;
         scale_ff   <= sgd_pkg::SCALE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            sgd_pkg::CSR_COLUMNS: columns_ff <= csr_data[sgd_pkg::COLUMNS_BITS-1:0];
            sgd_pkg::CSR_ROWS:    rows_ff    <= csr_data[sgd_pkg::ROWS_BITS-1:0];
            sgd_pkg::CSR_SCALE:   scale_ff   <= csr_data[sgd_pkg::SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // accept stage: position in the grid and line memory read
   logic [IDX_BITS-1:0]           column_count_ff, column_count_in;
   logic [sgd_pkg::ROWS_BITS-1:0] row_count_ff, row_count_in;
   logic [COL_BITS-1:0]           cols_eff, cols_m1;
   logic [sgd_pkg::ROWS_BITS-1:0] rows_m1;
   logic                          last_col, last_row;
   logic [IDX_BITS-1:0]           idx;
   logic                          req_fire;
   logic                          s1_valid_ff;
   cell_type                      s1_ff, s1_in;
   logic [VB-1:0]                 v_line_mem [MAX_COLUMNS];
   logic [VB-1:0]                 rd_data_ff;

   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      cols_eff = COL_BITS'(columns_ff);
      if (cols_eff == '0) begin
         cols_eff = COL_BITS'(1);
      end else if (cols_eff > COL_BITS'(MAX_COLUMNS)) begin
         cols_eff = COL_BITS'(MAX_COLUMNS);
      end
      cols_m1  = cols_eff - COL_BITS'(1);
      last_col = COL_BITS'(column_count_ff) >= cols_m1;
      idx      = last_col ? cols_m1[IDX_BITS-1:0] : column_count_ff;
      rows_m1  = (rows_ff == '0) ? '0 : rows_ff - 1'b1;
      last_row = row_count_ff >= rows_m1;

      if (last_col) begin
         column_count_in = '0;
         row_count_in    = last_row ? '0 : row_count_ff + 1'b1;
      end else begin
         column_count_in = idx + 1'b1;
         row_count_in    = row_count_ff;
      end

      s1_in.idx      = idx;
      s1_in.first    = (idx == '0);
      s1_in.last_col = last_col;
      priority if (rows_m1 == '0) begin
         s1_in.dv_sel = sgd_pkg::DV_TOP_BOTTOM;
      end else if (row_count_ff == '0) begin
         s1_in.dv_sel = sgd_pkg::DV_V_BOTTOM;
      end else if (last_row) begin
         s1_in.dv_sel = sgd_pkg::DV_TOP_BELOW;
      end else begin
         s1_in.dv_sel = sgd_pkg::DV_V_BELOW;
      end
      s1_in.fwd   = s1_valid_ff && (s1_ff.idx == idx);
      s1_in.fwd_v = s1_ff.v;
      s1_in.u     = req_chan.u_value;
      s1_in.v     = req_chan.v_value;
      s1_in.top   = req_chan.top_value;
      s1_in.bot   = req_chan.bottom_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
         if (req_fire) begin
            column_count_ff <= column_count_in;
            row_count_ff    <= row_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff      <= s1_in;
         rd_data_ff <= v_line_mem[idx];
      end
      if (s1_valid_ff) begin
         v_line_mem[s1_ff.idx] <= s1_ff.v;
      end
   end

   // difference stage
   logic signed [VB-1:0]       first_u_ff;
   logic signed [VB-1:0]       held_u_ff;
   logic signed [DV_BITS-1:0]  held_ydiff_ff;
   logic signed [VB-1:0]       u_s, v_prev, dv_a, dv_b, first_u_eff;
   logic signed [DV_BITS-1:0]  dv;
   logic signed [SUM_BITS-1:0] sum0, sum1;
   logic                       push0, push1;
   result_type                 res0, res1;

   always_comb begin
      u_s    = signed'(s1_ff.u);
      v_prev = s1_ff.fwd ? signed'(s1_ff.fwd_v) : signed'(rd_data_ff);
      unique case (s1_ff.dv_sel)
         sgd_pkg::DV_TOP_BOTTOM: begin
            dv_a = signed'(s1_ff.top);
            dv_b = signed'(s1_ff.bot);
         end
         sgd_pkg::DV_V_BOTTOM: begin
            dv_a = signed'(s1_ff.v);
            dv_b = signed'(s1_ff.bot);
         end
         sgd_pkg::DV_TOP_BELOW: begin
            dv_a = signed'(s1_ff.top);
            dv_b = v_prev;
         end
         default: begin
            dv_a = signed'(s1_ff.v);
            dv_b = v_prev;
         end
      endcase
      dv          = DV_BITS'(dv_a) - DV_BITS'(dv_b);
      first_u_eff = s1_ff.first ? u_s : first_u_ff;
      sum0 = SUM_BITS'(u_s) - SUM_BITS'(held_u_ff) + SUM_BITS'(held_ydiff_ff);
      sum1 = SUM_BITS'(first_u_eff) - SUM_BITS'(u_s) + SUM_BITS'(dv);
      push0    = s1_valid_ff && !s1_ff.first;
      push1    = s1_valid_ff && s1_ff.last_col;
      res0.div  = sat_sum(sum0);
      res0.last = !s1_ff.last_col;
      res1.div  = sat_sum(sum1);
      res1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_u_ff    <= '0;
         held_u_ff     <= '0;
         held_ydiff_ff <= '0;
      end else if (s1_valid_ff) begin
         if (s1_ff.first) begin
            first_u_ff <= u_s;
         end
         if (!s1_ff.last_col) begin
            held_u_ff     <= u_s;
            held_ydiff_ff <= dv;
         end
      end
   end

   // result queue
   result_type           queue_mem [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] q_count_ff, q_count_in;
   logic [QCHK_BITS-1:0] q_need;
   logic                 pop;

   always_comb begin
      wr_ptr_in  = wr_ptr_ff + QPTR_BITS'(push0) + QPTR_BITS'(push1);
      rd_ptr_in  = rd_ptr_ff + QPTR_BITS'(pop);
      q_count_in = q_count_ff + QCNT_BITS'(push0) + QCNT_BITS'(push1) - QCNT_BITS'(pop);
      q_need     = QCHK_BITS'(q_count_ff) + (QCHK_BITS'(s1_valid_ff) << 1) + QCHK_BITS'(2);
   end

   assign req_chan.ready = (q_need <= QCHK_BITS'(QDEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         queue_mem[wr_ptr_ff] <= res0;
      end else if (push1) begin
         queue_mem[wr_ptr_ff] <= res1;
      end
      if (push0 && push1) begin
         queue_mem[wr_ptr_ff + 1'b1] <= res1;
      end
   end

   // scale multiply and output register
   logic                        p_valid_ff;
   logic signed [PROD_BITS-1:0] p_ff, p_in;
   logic                        p_last_ff;
   logic                        out_valid_ff;
   logic [VB-1:0]               out_div_ff;
   logic                        out_last_ff;
   logic                        out_adv, p_adv;
   result_type                  q_head;

   always_comb begin
      out_adv = !out_valid_ff || rsp_chan.ready;
      p_adv   = !p_valid_ff || out_adv;
      pop     = (q_count_ff != '0) && p_adv;
      q_head  = queue_mem[rd_ptr_ff];
      p_in    = PROD_BITS'(signed'(q_head.div)) *
                PROD_BITS'(signed'({1'b0, scale_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (p_adv) begin
            p_valid_ff <= pop;
         end
         if (out_adv) begin
            out_valid_ff <= p_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p_ff      <= p_in;
         p_last_ff <= q_head.last;
      end
      if (out_adv && p_valid_ff) begin
         out_div_ff  <= sat_prod(p_ff);
         out_last_ff <= p_last_ff;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.divergence  = signed'(out_div_ff);
   assign rsp_chan.last_of_run = out_last_ff;

endmodule

// ===== hw/rtl/sgd_checker.sv =====
module sgd_checker #(
   parameter int VALUE_BITS = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [VALUE_BITS-1:0] rsp_divergence,
   input logic                  rsp_last_of_run
);

   // queue and pipeline empty after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_divergence)
         && $stable(rsp_last_of_run))
      else $error("stalled result changed");

endmodule

bind staggered_grid_divergence_unit sgd_checker #(
   .VALUE_BITS (VALUE_BITS)
) u_sgd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_divergence  (rsp_chan.divergence),
   .rsp_last_of_run (rsp_chan.last_of_run)
);
